// ===== rtl/core/kms_pkg.sv =====
package kms_pkg;

	localparam int unsigned NUM_ROWS    = 7;
	localparam int unsigned NUM_COLUMNS = 8;
	localparam int unsigned ROW_W       = 3;
	localparam int unsigned COL_W       = 3;
	localparam int unsigned CODE_W      = 8;
	localparam int unsigned CFG_IDX_W   = 1;

	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [CODE_W-1:0] code_t;
	typedef logic [1:0]        bl_t;

	localparam row_t LAST_ROW = row_t'(NUM_ROWS - 1);

	// modifier classes as held in the plain keymap
	localparam code_t MOD_SHIFT = 8'h01;
	localparam code_t MOD_ALT   = 8'h02;
	localparam code_t CODE_BS   = 8'h08;

	localparam bl_t BL_NONE = 2'd0;
	localparam bl_t BL_ON   = 2'd1;
	localparam bl_t BL_OFF  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_ONE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_TWO = 1'd1;

	localparam code_t FUNCTION_ONE_RESET = 8'd128;
	localparam code_t FUNCTION_TWO_RESET = 8'd129;

	// special positions
	localparam row_t FN1_ROW   = 3'd5;
	localparam col_t FN1_COL   = 3'd1;
	localparam row_t FN2_ROW   = 3'd2;
	localparam col_t FN2_COL   = 3'd7;
	localparam row_t VOL_ROW   = 3'd3;
	localparam col_t VOLUP_COL = 3'd5;
	localparam col_t VOLDN_COL = 3'd7;

	typedef code_t keymap_t [NUM_ROWS][NUM_COLUMNS];

	// function key positions hold zero and are replaced by registers
	localparam keymap_t ROM_PLAIN = '{
		'{8'h00, 8'h00, "u",   "5",   "4",     "2",     "i",     "3"},
		'{8'h00, 8'h00, "7",   "6",   "r",     "w",     "0",     "e"},
		'{8'h00, 8'h00, "k",   "b",   "v",     MOD_ALT, "o",     8'h00},
		'{CODE_BS, MOD_SHIFT, "j", "h", "g",   8'h00,   "l",     8'h00},
		'{8'h0a, "a",   "m",   "n",   "c",     "s",     ",",     "x"},
		'{MOD_SHIFT, 8'h00, ".", " ", "@",     "z",     MOD_ALT, "f"},
		'{"p",   "q",   "8",   "y",   "t",     "1",     "9",     "d"}
	};

	localparam keymap_t ROM_UPPER = '{
		'{8'h00, 8'h00, "U",   "%",   "$",     "@",     "I",     "#"},
		'{8'h00, 8'h00, "&",   "^",   "R",     "W",     ")",     "E"},
		'{8'h00, 8'h00, "K",   "B",   "V",     MOD_ALT, "O",     8'h00},
		'{CODE_BS, MOD_SHIFT, "J", "H", "G",   8'h00,   "L",     8'h00},
		'{8'h0a, "A",   "M",   "N",   "C",     "S",     "?",     "X"},
		'{MOD_SHIFT, 8'h00, "/", " ", "~",     "Z",     MOD_ALT, "F"},
		'{"P",   "Q",   "*",   "Y",   "T",     "!",     "(",     "D"}
	};

	localparam keymap_t ROM_ALT = '{
		'{8'h00, 8'h00, "x",   "%",   "$",     "@",     "-",     "#"},
		'{8'h00, 8'h00, "&",   "^",   "R",     8'h27,   ")",     "_"},
		'{8'h00, 8'h00, 8'h22, "]",   "[",     MOD_ALT, "+",     8'h00},
		'{CODE_BS, MOD_SHIFT, ";", ":", "}",   8'h00,   "L",     8'h00},
		'{8'h0a, "A",   ">",   "<",   "C",     "|",     "?",     "X"},
		'{MOD_SHIFT, 8'h00, "/", " ", "~",     "Z",     MOD_ALT, "{"},
		'{"=",   8'h09, "*",   "/",   "T",     "!",     "(",     8'h5c}
	};

	// what one row sample contributes
	typedef struct packed {
		logic shift_hit;
		logic alt_hit;
		logic key_hit;
		col_t key_col;
	} row_hit_t;

	// outcome of a completed scan
	typedef struct packed {
		logic  key_valid;
		code_t key_code;
		bl_t   backlight;
		code_t held_next;
	} scan_res_t;

endpackage

// ===== rtl/core/kms_row_pick.sv =====
module kms_row_pick (
	input  kms_pkg::row_t     row,
	input  logic [7:0]        column_sample,
	output kms_pkg::row_hit_t hit
);

	always_comb begin
		logic         fkey;
		kms_pkg::code_t cls;
		hit = '0;
		for (int c = 0; c < kms_pkg::NUM_COLUMNS; c++) begin
			cls  = kms_pkg::ROM_PLAIN[row][c];
			fkey = (row == kms_pkg::FN1_ROW && kms_pkg::col_t'(c) == kms_pkg::FN1_COL) ||
			       (row == kms_pkg::FN2_ROW && kms_pkg::col_t'(c) == kms_pkg::FN2_COL);
			if (!column_sample[c]) begin
				if (!fkey && cls == kms_pkg::MOD_SHIFT) begin
					hit.shift_hit = 1'b1;
				end else if (!fkey && cls == kms_pkg::MOD_ALT) begin
					hit.alt_hit = 1'b1;
				end else begin
					// later column overwrites: last pressed wins
					hit.key_hit = 1'b1;
					hit.key_col = kms_pkg::col_t'(c);
				end
			end
		end
	end

endmodule

// ===== rtl/core/kms_key_map.sv =====
module kms_key_map (
	input  logic               key_found,
	input  kms_pkg::row_t      found_row,
	input  kms_pkg::col_t      found_col,
	input  logic               shift_seen,
	input  logic               alt_seen,
	input  kms_pkg::code_t     function_one_code,
	input  kms_pkg::code_t     function_two_code,
	input  kms_pkg::code_t     held_key,
	output kms_pkg::scan_res_t res
);

	kms_pkg::code_t code;
	kms_pkg::row_t  r;

	// found_row never exceeds the last row; clamp keeps the index in range
	assign r = (found_row > kms_pkg::LAST_ROW) ? kms_pkg::LAST_ROW : found_row;

	always_comb begin
		if (r == kms_pkg::FN1_ROW && found_col == kms_pkg::FN1_COL) begin
			code = function_one_code;
		end else if (r == kms_pkg::FN2_ROW && found_col == kms_pkg::FN2_COL) begin
			code = function_two_code;
		end else if (alt_seen) begin
			code = kms_pkg::ROM_ALT[r][found_col];
		end else if (shift_seen) begin
			code = kms_pkg::ROM_UPPER[r][found_col];
		end else begin
			code = kms_pkg::ROM_PLAIN[r][found_col];
		end
	end

	always_comb begin
		res           = '0;
		res.backlight = kms_pkg::BL_NONE;
		res.held_next = held_key;
		if (!key_found) begin
			res.held_next = '0;
		end else if (code == '0) begin
			res.held_next = '0;
			if (r == kms_pkg::VOL_ROW && found_col == kms_pkg::VOLUP_COL) begin
				res.backlight = kms_pkg::BL_ON;
			end else if (r == kms_pkg::VOL_ROW && found_col == kms_pkg::VOLDN_COL) begin
				res.backlight = kms_pkg::BL_OFF;
			end
		end else if (code != held_key) begin
			res.held_next = code;
			res.key_valid = 1'b1;
			res.key_code  = code;
		end
	end

endmodule

// ===== rtl/core/keypad_matrix_scanner.sv =====
// Keypad matrix scanner, 7 rows by 8 columns.
// Input channel (in_valid / in_stall / column_sample): one transfer per row
// sample, active-low columns of the row last announced on drive_row.
// Output channel (out_valid / out_stall and the result fields): exactly one
// transfer per input transfer, in order. drive_row names the row to sample
// next; scan_done marks the last row of a scan, and only then can key_valid,
// key_code or backlight_cmd be non-zero.
// A sample is captured in an input register, then the row pick, flag update
// and keymap lookup sit between it and the result register. Throughput: one
// sample per cycle while out_stall does not hold the result register, set by
// the single pass through that logic; scan state updates as the result is
// registered.
// Configuration (cfg_write / cfg_index / cfg_data) sets the two function key
// codes; write only while idle.
// Reset clears the row counter, modifier flags, found position and held key;
// function codes return to 128 and 129. When out_stall is held the result
// register keeps its value, the input register fills, then in_stall rises.
module keypad_matrix_scanner (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_write,
	input  logic [kms_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [kms_pkg::CODE_W-1:0]            cfg_data,
	// sample channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [7:0]                            column_sample,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [2:0]                            drive_row,
	output logic                                  scan_done,
	output logic                                  key_valid,
	output logic [7:0]                            key_code,
	output logic [1:0]                            backlight_cmd
);

	// registers
	kms_pkg::code_t     function_one_q, function_two_q;
	logic               valid_s1;
	logic [7:0]         sample_s1;
	kms_pkg::row_t      row_q;
	logic               shift_q, alt_q, found_q;
	kms_pkg::row_t      found_row_q;
	kms_pkg::col_t      found_col_q;
	kms_pkg::code_t     held_q;

	// next-state logic
	logic               advance, fire;
	kms_pkg::row_t      row;
	logic               last;
	kms_pkg::row_hit_t  hit;
	logic               shift_n, alt_n, found_n;
	kms_pkg::row_t      found_row_n;
	kms_pkg::col_t      found_col_n;
	kms_pkg::row_t      row_next;
	kms_pkg::scan_res_t res;

	// result register frees up when empty or being taken
	assign advance  = !out_valid || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	assign row  = (row_q > kms_pkg::LAST_ROW) ? kms_pkg::LAST_ROW : row_q;
	assign last = (row == kms_pkg::LAST_ROW);

	kms_row_pick u_pick (
		.row           (row),
		.column_sample (sample_s1),
		.hit           (hit)
	);

	// fold this row into the running scan before the lookup
	assign shift_n     = shift_q | hit.shift_hit;
	assign alt_n       = alt_q | hit.alt_hit;
	assign found_n     = found_q | hit.key_hit;
	assign found_row_n = hit.key_hit ? row : found_row_q;
	assign found_col_n = hit.key_hit ? hit.key_col : found_col_q;
	assign row_next    = last ? '0 : row + 3'd1;

	kms_key_map u_map (
		.key_found         (found_n),
		.found_row         (found_row_n),
		.found_col         (found_col_n),
		.shift_seen        (shift_n),
		.alt_seen          (alt_n),
		.function_one_code (function_one_q),
		.function_two_code (function_two_q),
		.held_key          (held_q),
		.res               (res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			function_one_q <= kms_pkg::FUNCTION_ONE_RESET;
			function_two_q <= kms_pkg::FUNCTION_TWO_RESET;
		end else if (cfg_write) begin
			if (cfg_index == kms_pkg::REG_FUNCTION_ONE) begin
				function_one_q <= cfg_data;
			end else if (cfg_index == kms_pkg::REG_FUNCTION_TWO) begin
				function_two_q <= cfg_data;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sample_s1 <= column_sample;
		end
	end

	// scan state, updated as each sample's result is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			shift_q     <= 1'b0;
			alt_q       <= 1'b0;
			found_q     <= 1'b0;
			found_row_q <= '0;
			found_col_q <= '0;
			held_q      <= '0;
		end else if (fire) begin
			row_q <= row_next;
			if (last) begin
				shift_q     <= 1'b0;
				alt_q       <= 1'b0;
				found_q     <= 1'b0;
				found_row_q <= '0;
				found_col_q <= '0;
				held_q      <= res.held_next;
			end else begin
				shift_q     <= shift_n;
				alt_q       <= alt_n;
				found_q     <= found_n;
				found_row_q <= found_row_n;
				found_col_q <= found_col_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			drive_row     <= row_next;
			scan_done     <= last;
			key_valid     <= last & res.key_valid;
			key_code      <= last ? res.key_code : '0;
			backlight_cmd <= last ? res.backlight : kms_pkg::BL_NONE;
		end
	end

endmodule

// ===== tb/tb.sv =====
module tb;
	import kms_pkg::*;

	// Own copy of the three keymaps, [row][column], row 0 column 0 first.
	// Function key positions hold zero and take the register value instead.
	localparam logic [0:6][0:7][7:0] PLAIN_KEYS = {
		8'h00,     8'h00,     "u", "5", "4", "2",     "i",     "3",
		8'h00,     8'h00,     "7", "6", "r", "w",     "0",     "e",
		8'h00,     8'h00,     "k", "b", "v", MOD_ALT, "o",     8'h00,
		CODE_BS,   MOD_SHIFT, "j", "h", "g", 8'h00,   "l",     8'h00,
		8'h0a,     "a",       "m", "n", "c", "s",     ",",     "x",
		MOD_SHIFT, 8'h00,     ".", " ", "@", "z",     MOD_ALT, "f",
		"p",       "q",       "8", "y", "t", "1",     "9",     "d"
	};

	localparam logic [0:6][0:7][7:0] UPPER_KEYS = {
		8'h00,     8'h00,     "U", "%", "$", "@",     "I",     "#",
		8'h00,     8'h00,     "&", "^", "R", "W",     ")",     "E",
		8'h00,     8'h00,     "K", "B", "V", MOD_ALT, "O",     8'h00,
		CODE_BS,   MOD_SHIFT, "J", "H", "G", 8'h00,   "L",     8'h00,
		8'h0a,     "A",       "M", "N", "C", "S",     "?",     "X",
		MOD_SHIFT, 8'h00,     "/", " ", "~", "Z",     MOD_ALT, "F",
		"P",       "Q",       "*", "Y", "T", "!",     "(",     "D"
	};

	localparam logic [0:6][0:7][7:0] ALT_KEYS = {
		8'h00,     8'h00,     "x",   "%", "$", "@",     "-",     "#",
		8'h00,     8'h00,     "&",   "^", "R", 8'h27,   ")",     "_",
		8'h00,     8'h00,     8'h22, "]", "[", MOD_ALT, "+",     8'h00,
		CODE_BS,   MOD_SHIFT, ";",   ":", "}", 8'h00,   "L",     8'h00,
		8'h0a,     "A",       ">",   "<", "C", "|",     "?",     "X",
		MOD_SHIFT, 8'h00,     "/",   " ", "~", "Z",     MOD_ALT, "{",
		"=",       8'h09,     "*",   "/", "T", "!",     "(",     8'h5c
	};

	// one result transfer, field for field
	typedef struct packed {
		row_t  drive_row;
		logic  scan_done;
		logic  key_valid;
		code_t key_code;
		bl_t   backlight;
	} scan_out_t;

	// directed row: sample plus an optional hand-written scan outcome
	typedef struct packed {
		code_t sample;
		logic  typed;
		logic  key_valid;
		code_t key_code;
		bl_t   backlight;
	} directed_row_t;

	localparam logic [11:0] UNTYPED = '0;
	localparam int DIRECTED_LEN = 28;

	// Four whole scans from row 0:
	//  every key down: both modifiers seen, alt wins, last position (row 6, col 7)
	//    gives the alted backslash; the magnifier position is an ordinary key here
	//  every key down again: same code as held, so nothing reported
	//  internal menu key alone: reset function code
	//  both volume keys: volume down is later in row-major order, backlight off
	localparam directed_row_t [0:DIRECTED_LEN-1] DIRECTED = {
		{8'h00, UNTYPED}, {8'h00, UNTYPED}, {8'h00, UNTYPED}, {8'h00, UNTYPED},
		{8'h00, UNTYPED}, {8'h00, UNTYPED}, {8'h00, 1'b1, 1'b1, 8'h5c, BL_NONE},
		{8'h00, UNTYPED}, {8'h00, UNTYPED}, {8'h00, UNTYPED}, {8'h00, UNTYPED},
		{8'h00, UNTYPED}, {8'h00, UNTYPED}, {8'h00, 1'b1, 1'b0, 8'h00, BL_NONE},
		{8'hff, UNTYPED}, {8'hff, UNTYPED}, {8'hff, UNTYPED}, {8'hff, UNTYPED},
		{8'hff, UNTYPED}, {8'hfd, UNTYPED},
		{8'hff, 1'b1, 1'b1, FUNCTION_ONE_RESET, BL_NONE},
		{8'hff, UNTYPED}, {8'hff, UNTYPED}, {8'hff, UNTYPED}, {8'h5f, UNTYPED},
		{8'hff, UNTYPED}, {8'hff, UNTYPED}, {8'hff, 1'b1, 1'b0, 8'h00, BL_OFF}
	};

	localparam code_t FN_CODE_MIN = 8'd3;
	localparam code_t FN_CODE_MAX = 8'd255;
	localparam int    PHASES = 5;
	localparam int    PHASE_SAMPLES = 125;
	localparam int unsigned QUIET_LIMIT = 1000;

	typedef enum int unsigned {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_RUNS} stall_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	code_t                cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	code_t                column_sample;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	row_t                 drive_row;
	logic                 scan_done;
	logic                 key_valid;
	code_t                key_code;
	bl_t                  backlight_cmd;

	keypad_matrix_scanner u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.column_sample (column_sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.drive_row     (drive_row),
		.scan_done     (scan_done),
		.key_valid     (key_valid),
		.key_code      (key_code),
		.backlight_cmd (backlight_cmd)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// scanner state as the testbench sees it
	row_t  scan_row;
	logic  saw_shift;
	logic  saw_alt;
	logic  have_key;
	row_t  key_row;
	col_t  key_col;
	code_t held_code;
	code_t fn_one_code;
	code_t fn_two_code;

	scan_out_t   pending_results [$];
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;

	// sender side
	int    sample_count = 0;
	int    burst_left = 0;
	logic  typed_on;
	logic  typed_valid;
	code_t typed_code;
	bl_t   typed_bl;
	code_t last_press [NUM_ROWS];

	// receiver side
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left = 0;
	int          run_left = 0;
	logic        run_level = 1'b0;

	// Advance the scanner by one row sample and return the result transfer it
	// should produce.
	function automatic scan_out_t advance_scan(input code_t sample);
		scan_out_t res;
		row_t      r;
		code_t     cls;
		code_t     code;
		logic      fkey;
		int        c;
		res = '0;
		r = (scan_row > LAST_ROW) ? LAST_ROW : scan_row;
		for (c = 0; c < NUM_COLUMNS; c++) begin
			if (!sample[c]) begin
				// modifier class comes from the plain map by position only
				cls  = PLAIN_KEYS[r][c];
				fkey = (r == FN1_ROW && c == FN1_COL) || (r == FN2_ROW && c == FN2_COL);
				if (!fkey && cls == MOD_SHIFT)
					saw_shift = 1'b1;
				else if (!fkey && cls == MOD_ALT)
					saw_alt = 1'b1;
				else begin
					have_key = 1'b1;
					key_row  = r;
					key_col  = col_t'(c);
				end
			end
		end
		if (r == LAST_ROW) begin
			res.scan_done = 1'b1;
			if (have_key) begin
				if (key_row == FN1_ROW && key_col == FN1_COL)
					code = fn_one_code;
				else if (key_row == FN2_ROW && key_col == FN2_COL)
					code = fn_two_code;
				else if (saw_alt)
					code = ALT_KEYS[key_row][key_col];
				else if (saw_shift)
					code = UPPER_KEYS[key_row][key_col];
				else
					code = PLAIN_KEYS[key_row][key_col];
				if (code == 8'h00) begin
					held_code = 8'h00;
					if (key_row == VOL_ROW && key_col == VOLUP_COL)
						res.backlight = BL_ON;
					else if (key_row == VOL_ROW && key_col == VOLDN_COL)
						res.backlight = BL_OFF;
				end else if (code != held_code) begin
					held_code    = code;
					res.key_valid = 1'b1;
					res.key_code  = code;
				end
			end else begin
				held_code = 8'h00;
			end
			saw_shift = 1'b0;
			saw_alt   = 1'b0;
			have_key  = 1'b0;
			key_row   = '0;
			key_col   = '0;
			scan_row  = '0;
		end else begin
			scan_row = r + row_t'(1);
		end
		res.drive_row = scan_row;
		return res;
	endfunction

	// Result checking, watchdog and prediction, all at the rising edge.
	// The output transfer is checked before this edge's input transfer is
	// queued, so a result can never be matched against its own sample.
	always @(posedge clk) begin : result_check
		scan_out_t want;
		scan_out_t seen;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen.drive_row = drive_row;
				seen.scan_done = scan_done;
				seen.key_valid = key_valid;
				seen.key_code  = key_code;
				seen.backlight = backlight_cmd;
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("stray result: row %0d done %0b valid %0b code %h bl %0d",
							seen.drive_row, seen.scan_done, seen.key_valid, seen.key_code,
							seen.backlight);
				end else begin
					want = pending_results.pop_front();
					if (seen !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("result mismatch at %0t", $time);
							$display("  expected row %0d done %0b valid %0b code %h bl %0d",
								want.drive_row, want.scan_done, want.key_valid, want.key_code,
								want.backlight);
							$display("  actual   row %0d done %0b valid %0b code %h bl %0d",
								seen.drive_row, seen.scan_done, seen.key_valid, seen.key_code,
								seen.backlight);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				want = advance_scan(column_sample);
				// hand-written outcome from the directed table overrides the scan fields
				if (typed_on) begin
					want.key_valid = typed_valid;
					want.key_code  = typed_code;
					want.backlight = typed_bl;
				end
				pending_results.push_back(want);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	// Result-side stall: modes change every so often, from no stall at all
	// through random stalls to long runs of stall and no stall.
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left  = $urandom_range(20, 200);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			STALL_NONE: begin
				out_stall <= 1'b0;
			end
			STALL_LIGHT: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			STALL_HALF: begin
				out_stall <= ($urandom_range(0, 1) == 1);
			end
			default: begin
				if (run_left == 0) begin
					run_left  = $urandom_range(1, 25);
					run_level = ~run_level;
				end
				run_left--;
				out_stall <= run_level;
			end
		endcase
	end

	// One sample transfer; called and returns at a falling edge. Bursts of
	// random length with random gaps before each one.
	task automatic send_sample(input code_t sample, input logic has_typed, input logic t_valid,
			input code_t t_code, input bl_t t_bl);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
				: $urandom_range(1, 12);
		end
		burst_left--;
		in_valid      = 1'b1;
		column_sample = sample;
		typed_on      = has_typed;
		typed_valid   = t_valid;
		typed_code    = t_code;
		typed_bl      = t_bl;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		sample_count++;
	endtask

	// Hold off until every queued result has been seen.
	task automatic drain_results();
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input code_t value);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		if (idx == REG_FUNCTION_ONE)
			fn_one_code = value;
		else
			fn_two_code = value;
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	// One full scan's worth of samples with random content. Scans start from
	// wherever the row pointer is, so noise transfers leave them misaligned.
	task automatic random_scan();
		code_t press [NUM_ROWS];
		int    kind;
		int    pick;
		int    n;
		int    r;
		kind = $urandom_range(0, 99);
		foreach (press[i])
			press[i] = '0;
		if (kind < 15) begin
			// same keys as last scan: repeat suppression
			press = last_press;
		end else if (kind >= 23 && kind < 35) begin
			foreach (press[i])
				press[i] = code_t'($urandom_range(0, 255));
		end else if (kind >= 35) begin
			if (kind < 50) begin
				// volume keys, function keys, zero-code corner
				pick = $urandom_range(0, 4);
				case (pick)
					0: press[VOL_ROW][VOLUP_COL] = 1'b1;
					1: press[VOL_ROW][VOLDN_COL] = 1'b1;
					2: press[FN1_ROW][FN1_COL] = 1'b1;
					3: press[FN2_ROW][FN2_COL] = 1'b1;
					default: press[$urandom_range(0, 2)][$urandom_range(0, 1)] = 1'b1;
				endcase
				if ($urandom_range(0, 2) == 0)
					press[$urandom_range(0, 6)][$urandom_range(0, 7)] = 1'b1;
			end else if (kind < 65) begin
				repeat ($urandom_range(2, 4))
					press[$urandom_range(0, 6)][$urandom_range(0, 7)] = 1'b1;
			end else begin
				press[$urandom_range(0, 6)][$urandom_range(0, 7)] = 1'b1;
			end
			// shift sits at row 3 col 1 and row 5 col 0, alt at row 2 col 5 and row 5 col 6
			pick = $urandom_range(0, 3);
			if (pick == 1 || pick == 3) begin
				if ($urandom_range(0, 1))
					press[3][1] = 1'b1;
				else
					press[5][0] = 1'b1;
			end
			if (pick >= 2) begin
				if ($urandom_range(0, 1))
					press[2][5] = 1'b1;
				else
					press[5][6] = 1'b1;
			end
		end
		last_press = press;
		for (n = 0; n < NUM_ROWS; n++) begin
			r = sample_count % NUM_ROWS;
			send_sample(~press[r], 1'b0, 1'b0, 8'h00, BL_NONE);
		end
	endtask

	initial begin : stimulus
		int    k;
		int    phase;
		code_t one_val;
		code_t two_val;
		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = REG_FUNCTION_ONE;
		cfg_data      = 8'h00;
		in_valid      = 1'b0;
		column_sample = 8'hff;
		typed_on      = 1'b0;
		typed_valid   = 1'b0;
		typed_code    = 8'h00;
		typed_bl      = BL_NONE;
		scan_row      = '0;
		saw_shift     = 1'b0;
		saw_alt       = 1'b0;
		have_key      = 1'b0;
		key_row       = '0;
		key_col       = '0;
		held_code     = 8'h00;
		fn_one_code   = FUNCTION_ONE_RESET;
		fn_two_code   = FUNCTION_TWO_RESET;
		foreach (last_press[i])
			last_press[i] = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed scans at the reset function codes
		for (k = 0; k < DIRECTED_LEN; k++)
			send_sample(DIRECTED[k].sample, DIRECTED[k].typed, DIRECTED[k].key_valid,
				DIRECTED[k].key_code, DIRECTED[k].backlight);

		// random phases, each under its own pair of function codes; the block
		// is drained before every register write
		for (phase = 0; phase < PHASES; phase++) begin
			drain_results();
			case (phase)
				0: begin
					one_val = FN_CODE_MIN;
					two_val = FN_CODE_MAX;
				end
				1: begin
					one_val = FN_CODE_MAX;
					two_val = FN_CODE_MIN;
				end
				default: begin
					one_val = code_t'($urandom_range(FN_CODE_MIN, FN_CODE_MAX));
					two_val = code_t'($urandom_range(FN_CODE_MIN, FN_CODE_MAX));
				end
			endcase
			write_reg(REG_FUNCTION_ONE, one_val);
			write_reg(REG_FUNCTION_TWO, two_val);
			k = sample_count + PHASE_SAMPLES;
			while (sample_count < k) begin
				// occasional stray samples throw the scan out of step
				if ($urandom_range(0, 19) == 0)
					repeat ($urandom_range(1, 3))
						send_sample(code_t'($urandom_range(0, 255)), 1'b0, 1'b0, 8'h00,
							BL_NONE);
				random_scan();
			end
		end

		in_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
